### rtl/weekly_alarm_pattern_sequencer_assert.svh
// Assertion macros shared by the weekly alarm pattern sequencer RTL.
`ifndef WEEKLY_ALARM_PATTERN_SEQUENCER_ASSERT_SVH
`define WEEKLY_ALARM_PATTERN_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define WAP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wap assertion failed");
`define WAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wap assertion failed");
`else
`define WAP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WAP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/wap_pkg.sv
// Package: types, constants and helpers of the weekly alarm pattern sequencer.
package wap_pkg;

   localparam int SCHED_DAYS_DEF    = 6;
   localparam int DAY_ENTRIES_DEF   = 24;
   localparam int PATTERN_COUNT_DEF = 4;
   localparam int PATTERN_STEPS_DEF = 12;

   localparam logic [7:0] LIST_END    = 8'd255;
   localparam logic [2:0] DAY_UNKNOWN = 3'd7;

   localparam logic [2:0] MODE_WRITE_ENTRY = 3'd0;
   localparam logic [2:0] MODE_WRITE_STEP  = 3'd1;
   localparam logic [2:0] MODE_RESYNC      = 3'd2;
   localparam logic [2:0] MODE_CHECK       = 3'd3;
   localparam logic [2:0] MODE_TICK        = 3'd4;

   localparam int REG_SIGNAL_ENABLE = 0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_CHK,
      ST_APPLY,
      ST_APPLY_WAIT,
      ST_STAT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] weekday;
      logic [4:0] slot;
      logic [7:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [1:0] pattern_select;
      logic [7:0] step_byte;
   } req_item_type;

   typedef struct packed {
      logic       output_level;
      logic       fired;
      logic [7:0] next_hour;
      logic [7:0] next_minute;
      logic       pattern_active;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [1:0] pattern;
   } sched_entry_type;

   typedef struct packed {
      logic            we;
      sched_entry_type wdata;
   } sched_wr_type;

   typedef struct packed {
      logic       we;
      logic [7:0] wdata;
   } pat_wr_type;

   function automatic logic day_ok(input logic [2:0] d, input int days);
      day_ok = (d != 3'd0) && (32'(d) <= days);
   endfunction

   function automatic int addr_width(input int depth);
      addr_width = (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

### rtl/wap_sched_mem.sv
// Schedule memory: one read/write port, registered read data.
module wap_sched_mem #(
   parameter int DEPTH = wap_pkg::SCHED_DAYS_DEF * wap_pkg::DAY_ENTRIES_DEF,
   parameter int AW    = wap_pkg::addr_width(DEPTH)
) (
   input  logic                     clock,
   input  logic [AW-1:0]            addr,
   input  wap_pkg::sched_wr_type    wr,
   output wap_pkg::sched_entry_type rd_data
);

   wap_pkg::sched_entry_type mem [DEPTH];
   wap_pkg::sched_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[addr] <= wr.wdata;
      end
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;

endmodule

### rtl/wap_pat_mem.sv
// Pattern step memory: one read/write port, registered read data.
module wap_pat_mem #(
   parameter int DEPTH = wap_pkg::PATTERN_COUNT_DEF * wap_pkg::PATTERN_STEPS_DEF,
   parameter int AW    = wap_pkg::addr_width(DEPTH)
) (
   input  logic                 clock,
   input  logic [AW-1:0]        addr,
   input  wap_pkg::pat_wr_type  wr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[addr] <= wr.wdata;
      end
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;

endmodule

### rtl/wap_ctrl.sv
// Sequencer: request decode, resync scan, time check, pattern stepping, status read.
module wap_ctrl #(
   parameter int SCHED_DAYS    = wap_pkg::SCHED_DAYS_DEF,
   parameter int DAY_ENTRIES   = wap_pkg::DAY_ENTRIES_DEF,
   parameter int PATTERN_COUNT = wap_pkg::PATTERN_COUNT_DEF,
   parameter int PATTERN_STEPS = wap_pkg::PATTERN_STEPS_DEF,
   parameter int SAW = wap_pkg::addr_width(SCHED_DAYS * DAY_ENTRIES),
   parameter int PAW = wap_pkg::addr_width(PATTERN_COUNT * PATTERN_STEPS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  wap_pkg::req_item_type    req,
   input  logic                     signal_enable,
   output logic                     busy,
   output logic                     rsp_valid,
   output wap_pkg::rsp_item_type    rsp,
   output logic [SAW-1:0]           sched_addr,
   output wap_pkg::sched_wr_type    sched_wr,
   input  wap_pkg::sched_entry_type sched_rd,
   output logic [PAW-1:0]           pat_addr,
   output wap_pkg::pat_wr_type      pat_wr,
   input  logic [7:0]               pat_rd
);

   localparam int EIW = $clog2(DAY_ENTRIES + 1);
   localparam int SIW = $clog2(PATTERN_STEPS);
   localparam logic [EIW-1:0] IDX_NONE = EIW'(DAY_ENTRIES);
   localparam logic [EIW-1:0] IDX_LAST = EIW'(DAY_ENTRIES - 1);
   localparam logic [SIW-1:0] STEP_END = SIW'(PATTERN_STEPS - 1);

   wap_pkg::state_type    state_ff, state_in;
   wap_pkg::req_item_type item_ff, item_in;
   wap_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  strobe_ff, strobe_in;
   logic [EIW-1:0]        entry_index_ff, entry_index_in;
   logic [2:0]            last_wd_ff, last_wd_in;
   logic [1:0]            active_ff, active_in;
   logic [SIW-1:0]        step_ff, step_in;
   logic [6:0]            ticks_ff, ticks_in;
   logic                  level_ff, level_in;
   logic                  running_ff, running_in;
   logic                  fired_ff, fired_in;
   logic [SIW-1:0]        s_ff, s_in;
   logic [EIW-1:0]        scan_ff, scan_in;
   logic [EIW-1:0]        prev_ff, prev_in;
   logic                  pend_ff, pend_in;
   logic [EIW-1:0]        idx_new;
   logic                  later;
   logic                  match;

   function automatic logic [SAW-1:0] spos(input logic [2:0] d, input logic [EIW-1:0] e);
      logic ok;
      ok   = wap_pkg::day_ok(d, SCHED_DAYS) && (32'(e) < DAY_ENTRIES);
      spos = ok ? SAW'((32'(d) - 32'd1) * DAY_ENTRIES + 32'(e)) : '0;
   endfunction

   function automatic logic [PAW-1:0] ppos(input logic [1:0] p, input logic [SIW-1:0] s);
      ppos = PAW'(32'(p) * PATTERN_STEPS + 32'(s));
   endfunction

   // entry later than the request time (resync)
   assign later = (sched_rd.hour > item_ff.hour)
               || (sched_rd.hour == item_ff.hour && sched_rd.minute > item_ff.minute)
               || (sched_rd.hour == item_ff.hour && sched_rd.minute == item_ff.minute
                   && sched_rd.second > item_ff.second);

   assign match = (sched_rd.hour != wap_pkg::LIST_END) && (sched_rd.hour == item_ff.hour)
               && (sched_rd.minute == item_ff.minute) && (sched_rd.second == item_ff.second);

   // day change resets the pending index unless the previous day was unknown
   assign idx_new = (last_wd_ff != item_ff.weekday && last_wd_ff != wap_pkg::DAY_UNKNOWN)
                  ? '0 : entry_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wap_pkg::ST_IDLE;
         strobe_ff      <= 1'b0;
         entry_index_ff <= IDX_NONE;
         last_wd_ff     <= wap_pkg::DAY_UNKNOWN;
         active_ff      <= '0;
         step_ff        <= '0;
         ticks_ff       <= '0;
         level_ff       <= 1'b0;
         running_ff     <= 1'b0;
         fired_ff       <= 1'b0;
         pend_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         strobe_ff      <= strobe_in;
         entry_index_ff <= entry_index_in;
         last_wd_ff     <= last_wd_in;
         active_ff      <= active_in;
         step_ff        <= step_in;
         ticks_ff       <= ticks_in;
         level_ff       <= level_in;
         running_ff     <= running_in;
         fired_ff       <= fired_in;
         pend_ff        <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      s_ff    <= s_in;
      scan_ff <= scan_in;
      prev_ff <= prev_in;
   end

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      rsp_in         = rsp_ff;
      strobe_in      = 1'b0;
      entry_index_in = entry_index_ff;
      last_wd_in     = last_wd_ff;
      active_in      = active_ff;
      step_in        = step_ff;
      ticks_in       = ticks_ff;
      level_in       = level_ff;
      running_in     = running_ff;
      fired_in       = fired_ff;
      s_in           = s_ff;
      scan_in        = scan_ff;
      prev_in        = prev_ff;
      pend_in        = pend_ff;
      sched_addr     = spos(last_wd_ff, entry_index_ff);
      sched_wr.we    = 1'b0;
      sched_wr.wdata = {item_ff.hour, item_ff.minute, item_ff.second, item_ff.pattern_select};
      pat_addr       = ppos(active_ff, s_ff);
      pat_wr.we      = 1'b0;
      pat_wr.wdata   = item_ff.step_byte;

      unique case (state_ff)
         wap_pkg::ST_IDLE: begin
            if (accept) begin
               item_in  = req;
               state_in = wap_pkg::ST_EXEC;
            end
         end
         wap_pkg::ST_EXEC: begin
            fired_in = 1'b0;
            state_in = wap_pkg::ST_STAT;
            unique case (item_ff.mode)
               wap_pkg::MODE_WRITE_ENTRY: begin
                  sched_addr  = spos(item_ff.weekday, EIW'(item_ff.slot));
                  sched_wr.we = wap_pkg::day_ok(item_ff.weekday, SCHED_DAYS)
                             && (32'(item_ff.slot) < DAY_ENTRIES);
               end
               wap_pkg::MODE_WRITE_STEP: begin
                  pat_addr  = ppos(item_ff.pattern_select, SIW'(item_ff.slot));
                  pat_wr.we = (32'(item_ff.slot) < PATTERN_STEPS)
                           && (32'(item_ff.pattern_select) < PATTERN_COUNT);
               end
               wap_pkg::MODE_RESYNC: begin
                  last_wd_in     = item_ff.weekday;
                  entry_index_in = IDX_NONE;
                  scan_in        = '0;
                  pend_in        = 1'b0;
                  if (wap_pkg::day_ok(item_ff.weekday, SCHED_DAYS)) begin
                     state_in = wap_pkg::ST_SCAN;
                  end
               end
               wap_pkg::MODE_CHECK: begin
                  last_wd_in     = item_ff.weekday;
                  entry_index_in = idx_new;
                  sched_addr     = spos(item_ff.weekday, idx_new);
                  if (wap_pkg::day_ok(item_ff.weekday, SCHED_DAYS) && idx_new != IDX_NONE) begin
                     state_in = wap_pkg::ST_CHK;
                  end
               end
               wap_pkg::MODE_TICK: begin
                  if (running_ff && ticks_ff != '0) begin
                     ticks_in = ticks_ff - 7'd1;
                     if (ticks_ff == 7'd1) begin
                        s_in     = step_ff;
                        state_in = wap_pkg::ST_APPLY;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         wap_pkg::ST_SCAN: begin
            // reads are issued one per cycle; each compare uses the data of the previous read
            sched_addr = spos(item_ff.weekday, scan_ff);
            scan_in    = scan_ff + EIW'(1);
            prev_in    = scan_ff;
            pend_in    = 1'b1;
            if (pend_ff) begin
               if (sched_rd.hour == wap_pkg::LIST_END) begin
                  pend_in  = 1'b0;
                  state_in = wap_pkg::ST_STAT;
               end else if (later) begin
                  entry_index_in = prev_ff;
                  pend_in        = 1'b0;
                  state_in       = wap_pkg::ST_STAT;
               end else if (prev_ff == IDX_LAST) begin
                  pend_in  = 1'b0;
                  state_in = wap_pkg::ST_STAT;
               end
            end
         end
         wap_pkg::ST_CHK: begin
            state_in = wap_pkg::ST_STAT;
            if (match) begin
               fired_in       = 1'b1;
               entry_index_in = entry_index_ff + EIW'(1);
               if (signal_enable && 32'(sched_rd.pattern) < PATTERN_COUNT) begin
                  active_in = sched_rd.pattern;
                  s_in      = '0;
                  state_in  = wap_pkg::ST_APPLY;
               end
            end
         end
         wap_pkg::ST_APPLY: begin
            if (s_ff >= STEP_END) begin
               level_in   = 1'b0;
               running_in = 1'b0;
               ticks_in   = '0;
               step_in    = '0;
               state_in   = wap_pkg::ST_STAT;
            end else begin
               state_in = wap_pkg::ST_APPLY_WAIT;
            end
         end
         wap_pkg::ST_APPLY_WAIT: begin
            level_in   = pat_rd[7];
            ticks_in   = pat_rd[6:0];
            step_in    = s_ff + SIW'(1);
            running_in = 1'b1;
            if (pat_rd[6:0] != 7'd0) begin
               state_in = wap_pkg::ST_STAT;
            end else begin
               // zero-length step: chain to the next one
               s_in     = s_ff + SIW'(1);
               state_in = wap_pkg::ST_APPLY;
            end
         end
         wap_pkg::ST_STAT: begin
            state_in = wap_pkg::ST_DONE;
         end
         wap_pkg::ST_DONE: begin
            rsp_in.output_level   = level_ff;
            rsp_in.fired          = fired_ff;
            rsp_in.pattern_active = running_ff;
            if (wap_pkg::day_ok(last_wd_ff, SCHED_DAYS) && entry_index_ff != IDX_NONE
                && sched_rd.hour != wap_pkg::LIST_END) begin
               rsp_in.next_hour   = sched_rd.hour;
               rsp_in.next_minute = {2'b00, sched_rd.minute};
            end else begin
               rsp_in.next_hour   = wap_pkg::LIST_END;
               rsp_in.next_minute = wap_pkg::LIST_END;
            end
            strobe_in = 1'b1;
            state_in  = wap_pkg::ST_IDLE;
         end
         default: begin
            state_in = wap_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != wap_pkg::ST_IDLE);
   assign rsp_valid = strobe_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/weekly_alarm_pattern_sequencer.sv
// Top level of the weekly alarm pattern sequencer: ports, register file, memories.
//
// Usage: drive the request fields with start high while busy is low; the request
// is taken at that edge and busy rises. Exactly one result follows per request:
// rsp_strobe is high for one cycle with the result fields, and busy is already
// low in that cycle, so the next request may be taken on the strobe edge.
// The receiver cannot stall; results must be taken when strobed.
// Every request passes through the states EXEC, STAT and DONE. A time check with
// an entry pending also reads that entry in CHK; a time check that starts a
// pattern, or a tick that ends a step, then applies pattern steps through APPLY
// and APPLY_WAIT, chaining over zero-length steps and ending the pattern when it
// runs into its last step. A resync on a day with a schedule scans the day's
// entries in SCAN, up to DAY_ENTRIES of them. The schedule and pattern memories
// are single-port with registered read data, read one entry per cycle.
// The APB register signal_enable (address 0) resets to 1; writes are to take effect
// between requests, which the user must keep to: the block itself does not enforce
// it. Reset clears the entry index, the current day and the pattern state; the
// memories keep their contents and read as undefined until written.
module weekly_alarm_pattern_sequencer #(
   parameter int SCHED_DAYS    = wap_pkg::SCHED_DAYS_DEF,
   parameter int DAY_ENTRIES   = wap_pkg::DAY_ENTRIES_DEF,
   parameter int PATTERN_COUNT = wap_pkg::PATTERN_COUNT_DEF,
   parameter int PATTERN_STEPS = wap_pkg::PATTERN_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [2:0]  req_weekday,
   input  logic [4:0]  req_slot,
   input  logic [7:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   input  logic [1:0]  req_pattern_select,
   input  logic [7:0]  req_step_byte,
   output logic        rsp_strobe,
   output logic        rsp_output_level,
   output logic        rsp_fired,
   output logic [7:0]  rsp_next_hour,
   output logic [7:0]  rsp_next_minute,
   output logic        rsp_pattern_active,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "weekly_alarm_pattern_sequencer_assert.svh"

   localparam int SDEPTH = SCHED_DAYS * DAY_ENTRIES;
   localparam int PDEPTH = PATTERN_COUNT * PATTERN_STEPS;
   localparam int SAW    = wap_pkg::addr_width(SDEPTH);
   localparam int PAW    = wap_pkg::addr_width(PDEPTH);

   logic                     enable_ff, enable_in;
   logic                     csr_write;
   logic                     csr_hit;
   wap_pkg::req_item_type    req_item;
   wap_pkg::rsp_item_type    rsp_item;
   logic [SAW-1:0]           sched_addr;
   wap_pkg::sched_wr_type    sched_wr;
   wap_pkg::sched_entry_type sched_rd;
   logic [PAW-1:0]           pat_addr;
   wap_pkg::pat_wr_type      pat_wr;
   logic [7:0]               pat_rd;

   // register file
   assign pready    = 1'b1;
   assign csr_hit   = (32'(paddr[2]) == wap_pkg::REG_SIGNAL_ENABLE);
   assign csr_write = psel && penable && pwrite && pready;
   assign enable_in = (csr_write && csr_hit) ? pwdata[0] : enable_ff;
   assign prdata    = csr_hit ? {31'd0, enable_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign req_item = '{mode: req_mode, weekday: req_weekday, slot: req_slot,
                       hour: req_hour, minute: req_minute, second: req_second,
                       pattern_select: req_pattern_select, step_byte: req_step_byte};

   wap_ctrl #(
      .SCHED_DAYS    (SCHED_DAYS),
      .DAY_ENTRIES   (DAY_ENTRIES),
      .PATTERN_COUNT (PATTERN_COUNT),
      .PATTERN_STEPS (PATTERN_STEPS),
      .SAW           (SAW),
      .PAW           (PAW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (start && !busy),
      .req           (req_item),
      .signal_enable (enable_ff),
      .busy          (busy),
      .rsp_valid     (rsp_strobe),
      .rsp           (rsp_item),
      .sched_addr    (sched_addr),
      .sched_wr      (sched_wr),
      .sched_rd      (sched_rd),
      .pat_addr      (pat_addr),
      .pat_wr        (pat_wr),
      .pat_rd        (pat_rd)
   );

   wap_sched_mem #(
      .DEPTH (SDEPTH),
      .AW    (SAW)
   ) u_sched_mem (
      .clock   (clock),
      .addr    (sched_addr),
      .wr      (sched_wr),
      .rd_data (sched_rd)
   );

   wap_pat_mem #(
      .DEPTH (PDEPTH),
      .AW    (PAW)
   ) u_pat_mem (
      .clock   (clock),
      .addr    (pat_addr),
      .wr      (pat_wr),
      .rd_data (pat_rd)
   );

   assign rsp_output_level   = rsp_item.output_level;
   assign rsp_fired          = rsp_item.fired;
   assign rsp_next_hour      = rsp_item.next_hour;
   assign rsp_next_minute    = rsp_item.next_minute;
   assign rsp_pattern_active = rsp_item.pattern_active;

   // a result is only strobed once the sequencer has returned to idle
   `WAP_ASSERT_IMPL(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   // a taken request always makes the block busy
   `WAP_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // the output line is never driven high without a running pattern
   `WAP_ASSERT_IMPL(a_level_running, clock, reset, rsp_strobe && !rsp_pattern_active,
                    !rsp_output_level)
   // no result without a request in flight during the previous cycle
   `WAP_ASSERT_IMPL(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))

endmodule

### bench/wap_checker.sv
// Checker for the weekly alarm pattern sequencer: predicts every result and compares it.
module wap_checker
   import wap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [2:0]  req_weekday,
   input  logic [4:0]  req_slot,
   input  logic [7:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [5:0]  req_second,
   input  logic [1:0]  req_pattern_select,
   input  logic [7:0]  req_step_byte,
   input  logic        rsp_strobe,
   input  logic        rsp_output_level,
   input  logic        rsp_fired,
   input  logic [7:0]  rsp_next_hour,
   input  logic [7:0]  rsp_next_minute,
   input  logic        rsp_pattern_active,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          mismatch_count,
   output int          outstanding
);

   localparam int DAYS     = SCHED_DAYS_DEF;
   localparam int ENTRIES  = DAY_ENTRIES_DEF;
   localparam int PATTERNS = PATTERN_COUNT_DEF;
   localparam int STEPS    = PATTERN_STEPS_DEF;

   sched_entry_type sched_mem [DAYS*ENTRIES];
   logic [7:0]      step_mem [PATTERNS*STEPS];

   logic       enable_q;
   logic [4:0] entry_idx;
   logic [2:0] cur_day;
   logic [1:0] act_pat;
   logic [3:0] step_idx;
   logic [6:0] ticks;
   logic       level_q;
   logic       running_q;

   rsp_item_type status_fifo [$];
   int errors = 0;

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic logic day_in_sched(input logic [2:0] d);
      return (d != 3'd0) && (int'(d) <= DAYS);
   endfunction

   function automatic int slot_of(input logic [2:0] d, input logic [4:0] e);
      return (int'(d) - 1) * ENTRIES + int'(e);
   endfunction

   function automatic logic has_pending(input logic [2:0] d);
      if (!day_in_sched(d) || entry_idx >= ENTRIES)
         return 1'b0;
      return sched_mem[slot_of(d, entry_idx)].hour != LIST_END;
   endfunction

   // Load step s of the active pattern; zero-length steps fall through at once.
   function automatic void run_steps(input int s);
      logic [7:0] b;
      for (int g = 0; g <= STEPS; g++) begin
         if (s >= STEPS - 1) begin
            level_q = 1'b0;
            running_q = 1'b0;
            ticks = '0;
            step_idx = '0;
            return;
         end
         b = step_mem[int'(act_pat) * STEPS + s];
         level_q = b[7];
         ticks = b[6:0];
         step_idx = 4'(s + 1);
         running_q = 1'b1;
         if (ticks != 0)
            return;
         s++;
      end
   endfunction

   function automatic rsp_item_type alarm_outcome(input req_item_type r);
      rsp_item_type    o;
      sched_entry_type e;
      logic            fire;
      fire = 1'b0;
      case (r.mode)
         MODE_WRITE_ENTRY: begin
            if (day_in_sched(r.weekday) && r.slot < ENTRIES)
               sched_mem[slot_of(r.weekday, r.slot)] =
                  {r.hour, r.minute, r.second, r.pattern_select};
         end
         MODE_WRITE_STEP: begin
            if (r.slot < STEPS && int'(r.pattern_select) < PATTERNS)
               step_mem[int'(r.pattern_select) * STEPS + int'(r.slot)] = r.step_byte;
         end
         MODE_RESYNC: begin
            cur_day = r.weekday;
            entry_idx = 5'(ENTRIES);
            if (day_in_sched(r.weekday)) begin
               for (int a = 0; a < ENTRIES; a++) begin
                  e = sched_mem[slot_of(r.weekday, 5'(a))];
                  if (e.hour == LIST_END)
                     break;
                  if ({e.hour, e.minute, e.second} > {r.hour, r.minute, r.second}) begin
                     entry_idx = 5'(a);
                     break;
                  end
               end
            end
         end
         MODE_CHECK: begin
            // an unknown day is taken over without rewinding the index
            if (cur_day != r.weekday) begin
               if (cur_day != DAY_UNKNOWN)
                  entry_idx = '0;
               cur_day = r.weekday;
            end
            if (has_pending(r.weekday)) begin
               e = sched_mem[slot_of(r.weekday, entry_idx)];
               if ({e.hour, e.minute, e.second} == {r.hour, r.minute, r.second}) begin
                  fire = 1'b1;
                  if (enable_q && int'(e.pattern) < PATTERNS) begin
                     act_pat = e.pattern;
                     run_steps(0);
                  end
                  entry_idx = entry_idx + 5'd1;
               end
            end
         end
         MODE_TICK: begin
            if (running_q && ticks != 0) begin
               ticks = ticks - 7'd1;
               if (ticks == 0)
                  run_steps(int'(step_idx));
            end
         end
         default: ;
      endcase
      o.output_level = level_q;
      o.fired = fire;
      if (has_pending(cur_day)) begin
         e = sched_mem[slot_of(cur_day, entry_idx)];
         o.next_hour = e.hour;
         o.next_minute = 8'(e.minute);
      end else begin
         o.next_hour = LIST_END;
         o.next_minute = LIST_END;
      end
      o.pattern_active = running_q;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      req_item_type r;
      if (reset) begin
         enable_q = 1'b1;
         entry_idx = 5'(ENTRIES);
         cur_day = DAY_UNKNOWN;
         act_pat = '0;
         step_idx = '0;
         ticks = '0;
         level_q = 1'b0;
         running_q = 1'b0;
         status_fifo.delete();
      end else begin
         if (psel && penable && pready && paddr == 3'(REG_SIGNAL_ENABLE * 4)) begin
            if (pwrite)
               enable_q = pwdata[0];
            else if (prdata !== {31'b0, enable_q})
               flag_mismatch("signal_enable read", int'(prdata), int'(enable_q));
         end
         if (rsp_strobe) begin
            got = {rsp_output_level, rsp_fired, rsp_next_hour, rsp_next_minute,
                   rsp_pattern_active};
            if (status_fifo.size() == 0) begin
               flag_mismatch("result with no request waiting", 1, 0);
            end else begin
               want = status_fifo.pop_front();
               if (got.output_level !== want.output_level)
                  flag_mismatch("output_level", got.output_level, want.output_level);
               if (got.fired !== want.fired)
                  flag_mismatch("fired", got.fired, want.fired);
               if (got.next_hour !== want.next_hour)
                  flag_mismatch("next_hour", got.next_hour, want.next_hour);
               if (got.next_minute !== want.next_minute)
                  flag_mismatch("next_minute", got.next_minute, want.next_minute);
               if (got.pattern_active !== want.pattern_active)
                  flag_mismatch("pattern_active", got.pattern_active, want.pattern_active);
            end
         end
         if (start && !busy) begin
            r = {req_mode, req_weekday, req_slot, req_hour, req_minute, req_second,
                 req_pattern_select, req_step_byte};
            status_fifo.push_back(alarm_outcome(r));
         end
      end
      mismatch_count <= errors;
      outstanding <= status_fifo.size();
   end

endmodule

### bench/tb_top.sv
// Testbench top of the weekly alarm pattern sequencer: clock, reset, stimulus and verdict.
module tb_top;
   import wap_pkg::*;

   localparam int DAYS     = SCHED_DAYS_DEF;
   localparam int ENTRIES  = DAY_ENTRIES_DEF;
   localparam int PATTERNS = PATTERN_COUNT_DEF;
   localparam int STEPS    = PATTERN_STEPS_DEF;
   localparam int REQ_GOAL = 870;

   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_mode = '0;
   logic [2:0]  req_weekday = '0;
   logic [4:0]  req_slot = '0;
   logic [7:0]  req_hour = '0;
   logic [5:0]  req_minute = '0;
   logic [5:0]  req_second = '0;
   logic [1:0]  req_pattern_select = '0;
   logic [7:0]  req_step_byte = '0;
   logic        rsp_strobe;
   logic        rsp_output_level;
   logic        rsp_fired;
   logic [7:0]  rsp_next_hour;
   logic [7:0]  rsp_next_minute;
   logic        rsp_pattern_active;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int mismatch_count;
   int outstanding;

   // copy of what was written to the schedule, used to aim time checks at entries
   sched_entry_type plan [DAYS*ENTRIES];
   int sent = 0;
   int gap_style = 1;
   bit start_on = 1'b0;

   weekly_alarm_pattern_sequencer u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_weekday(req_weekday), .req_slot(req_slot),
      .req_hour(req_hour), .req_minute(req_minute), .req_second(req_second),
      .req_pattern_select(req_pattern_select), .req_step_byte(req_step_byte),
      .rsp_strobe(rsp_strobe), .rsp_output_level(rsp_output_level),
      .rsp_fired(rsp_fired), .rsp_next_hour(rsp_next_hour),
      .rsp_next_minute(rsp_next_minute), .rsp_pattern_active(rsp_pattern_active),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   wap_checker u_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_weekday(req_weekday), .req_slot(req_slot),
      .req_hour(req_hour), .req_minute(req_minute), .req_second(req_second),
      .req_pattern_select(req_pattern_select), .req_step_byte(req_step_byte),
      .rsp_strobe(rsp_strobe), .rsp_output_level(rsp_output_level),
      .rsp_fired(rsp_fired), .rsp_next_hour(rsp_next_hour),
      .rsp_next_minute(rsp_next_minute), .rsp_pattern_active(rsp_pattern_active),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .mismatch_count(mismatch_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic req_item_type noise();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[$bits(req_item_type)-1:0];
   endfunction

   function automatic int pick_gap();
      int p;
      if (gap_style == 0)
         return 0;
      p = $urandom_range(99);
      if (p < 65)
         return 0;
      if (p < 96)
         return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic int list_len(input int d);
      for (int s = 0; s < ENTRIES; s++)
         if (plan[(d - 1) * ENTRIES + s].hour == LIST_END)
            return s;
      return ENTRIES;
   endfunction

   task automatic send(input req_item_type it);
      int g;
      {req_mode, req_weekday, req_slot, req_hour, req_minute, req_second,
       req_pattern_select, req_step_byte} <= it;
      start <= 1'b1;
      start_on = 1'b1;
      do @(posedge clock); while (busy);
      if (it.mode == MODE_WRITE_ENTRY && it.weekday != 3'd0 && int'(it.weekday) <= DAYS
          && it.slot < ENTRIES)
         plan[(int'(it.weekday) - 1) * ENTRIES + int'(it.slot)] =
            {it.hour, it.minute, it.second, it.pattern_select};
      sent++;
      g = pick_gap();
      if (g > 0) begin
         start <= 1'b0;
         start_on = 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic timed(input logic [2:0] mode, input logic [2:0] wd, input logic [7:0] h,
                        input logic [5:0] m, input logic [5:0] s);
      req_item_type it;
      it = noise();
      it.mode = mode;
      it.weekday = wd;
      it.hour = h;
      it.minute = m;
      it.second = s;
      send(it);
   endtask

   task automatic put_entry(input int d, input int slot, input logic [7:0] h,
                            input logic [5:0] m, input logic [5:0] s, input logic [1:0] p);
      req_item_type it;
      it = noise();
      it.mode = MODE_WRITE_ENTRY;
      it.weekday = 3'(d);
      it.slot = 5'(slot);
      it.hour = h;
      it.minute = m;
      it.second = s;
      it.pattern_select = p;
      send(it);
   endtask

   task automatic put_step(input int p, input int slot, input logic [7:0] b);
      req_item_type it;
      it = noise();
      it.mode = MODE_WRITE_STEP;
      it.pattern_select = 2'(p);
      it.slot = 5'(slot);
      it.step_byte = b;
      send(it);
   endtask

   task automatic tick();
      req_item_type it;
      it = noise();
      it.mode = MODE_TICK;
      send(it);
   endtask

   // n ascending entries, then the end marker if n < ENTRIES; whole also fills the slots past it
   task automatic program_day(input int d, input int n, input bit whole);
      int t;
      t = $urandom_range(0, 600);
      for (int s = 0; s < ENTRIES; s++) begin
         if (s > n && !whole)
            break;
         if (s < n) begin
            t += $urandom_range(1, 3000);
            put_entry(d, s, 8'(t / 3600), 6'((t / 60) % 60), 6'(t % 60), 2'($urandom()));
         end else if (s == n) begin
            put_entry(d, s, LIST_END, 6'($urandom()), 6'($urandom()), 2'($urandom()));
         end else begin
            put_entry(d, s, 8'($urandom()), 6'($urandom()), 6'($urandom()),
                      2'($urandom()));
         end
      end
   endtask

   task automatic program_pattern(input int p);
      int r;
      logic [6:0] len;
      for (int s = 0; s < STEPS; s++) begin
         r = $urandom_range(99);
         if (r < 70)
            len = 7'($urandom_range(0, 3));
         else if (r < 95)
            len = 7'($urandom_range(4, 9));
         else
            len = 7'($urandom());
         put_step(p, s, {1'($urandom()), len});
      end
   endtask

   // bring a day to a known index, then hit its entries one after another
   task automatic walk_day(input int d);
      int len;
      int first;
      sched_entry_type e;
      len = list_len(d);
      if ($urandom_range(1) == 1) begin
         first = $urandom_range(0, len);
         if (first == 0) begin
            timed(MODE_RESYNC, 3'(d), '0, '0, '0);
         end else begin
            e = plan[(d - 1) * ENTRIES + first - 1];
            timed(MODE_RESYNC, 3'(d), e.hour, e.minute, e.second);
         end
      end else begin
         first = 0;
         timed(MODE_CHECK, 3'(d % DAYS + 1), 8'($urandom()), 6'($urandom()),
               6'($urandom()));
      end
      for (int j = first; j < len; j++) begin
         repeat ($urandom_range(0, 3)) tick();
         if ($urandom_range(7) == 0)
            timed(MODE_CHECK, 3'(d), 8'($urandom_range(0, 23)), 6'($urandom()),
                  6'($urandom()));
         e = plan[(d - 1) * ENTRIES + j];
         timed(MODE_CHECK, 3'(d), e.hour, e.minute, e.second);
      end
   endtask

   task automatic wait_idle();
      if (start_on) begin
         start <= 1'b0;
         start_on = 1'b0;
      end
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= 3'(REG_SIGNAL_ENABLE * 4);
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_enable(input logic v);
      wait_idle();
      csr_access(1'b1, ($urandom() & 32'hFFFF_FFFE) | 32'(v));
      if ($urandom_range(1) == 1)
         csr_access(1'b0, $urandom());
   endtask

   initial begin
      int goal;
      int pick;
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every schedule entry and pattern step is written before anything reads them
      for (int d = 1; d <= DAYS; d++)
         program_day(d, $urandom_range(1, 8), 1'b1);
      for (int p = 0; p < PATTERNS; p++)
         program_pattern(p);

      // day still unknown after reset: taken over, nothing pending
      timed(MODE_CHECK, 3'd1, '0, '0, '0);
      timed(MODE_SPARE_LO, 3'($urandom()), 8'($urandom()), 6'($urandom()), 6'($urandom()));
      timed(MODE_SPARE_HI, 3'($urandom()), 8'($urandom()), 6'($urandom()), 6'($urandom()));
      // writes outside the tables are dropped
      put_entry(0, 0, 8'd1, 6'd2, 6'd3, 2'd0);
      put_entry(7, 5, 8'd1, 6'd2, 6'd3, 2'd0);
      put_entry(1, ENTRIES, 8'd1, 6'd2, 6'd3, 2'd0);
      put_step(2, STEPS, 8'hFF);
      put_entry(1, 0, 8'd0, 6'd0, 6'd0, 2'd0);
      put_entry(1, 1, 8'd12, 6'd30, 6'd45, 2'd1);
      put_entry(1, 2, 8'd254, 6'd59, 6'd59, 2'd3);
      put_entry(1, 3, LIST_END, 6'd63, 6'd63, 2'd2);
      // pattern 0 opens with a zero-length step that falls through
      put_step(0, 0, 8'h80);
      put_step(0, 1, 8'h82);
      put_step(0, 2, 8'h00);
      // day change rewinds, then fire, tick, restart while running, list end
      timed(MODE_CHECK, 3'd2, 8'd255, 6'd63, 6'd63);
      timed(MODE_CHECK, 3'd1, 8'd0, 6'd0, 6'd0);
      tick();
      tick();
      timed(MODE_CHECK, 3'd1, 8'd12, 6'd30, 6'd45);
      timed(MODE_CHECK, 3'd1, 8'd254, 6'd59, 6'd59);
      timed(MODE_CHECK, 3'd1, 8'd255, 6'd63, 6'd63);
      timed(MODE_RESYNC, 3'd1, 8'd12, 6'd30, 6'd44);
      timed(MODE_RESYNC, 3'd1, 8'd255, 6'd63, 6'd63);
      // Sunday has no schedule
      timed(MODE_RESYNC, 3'd0, 8'd0, 6'd0, 6'd0);
      timed(MODE_CHECK, 3'd0, 8'd0, 6'd0, 6'd0);
      tick();
      // disabled: entry still advances, no pattern starts
      set_enable(1'b0);
      timed(MODE_RESYNC, 3'd1, 8'd0, 6'd0, 6'd0);
      timed(MODE_CHECK, 3'd1, 8'd12, 6'd30, 6'd45);
      set_enable(1'b1);

      goal = sent + REQ_GOAL;
      for (int ph = 0; sent < goal; ph++) begin
         set_enable((ph % 4 == 3) ? 1'b0 : 1'b1);
         gap_style = (ph % 3 == 0) ? 0 : 1;
         repeat (10) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
               n = $urandom_range(99);
               n = (n < 10) ? 0 : (n < 20) ? ENTRIES : $urandom_range(1, 8);
               program_day($urandom_range(1, DAYS), n, 1'b0);
            end else if (pick < 20) begin
               program_pattern($urandom_range(0, PATTERNS - 1));
            end else if (pick < 75) begin
               walk_day($urandom_range(1, DAYS));
            end else if (pick < 88) begin
               repeat ($urandom_range(1, 12)) tick();
            end else begin
               repeat ($urandom_range(1, 4)) send(noise());
            end
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/wap_pkg.sv
rtl/wap_sched_mem.sv
rtl/wap_pat_mem.sv
rtl/wap_ctrl.sv
rtl/weekly_alarm_pattern_sequencer.sv
bench/wap_checker.sv
bench/tb_top.sv
